>>> rtl/ldfw_pkg.sv
// Shared types and constants for the two-wire LED driver frame writer.
package ldfw_pkg;

   // Word operation codes
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_SEND  = 2'd1;
   localparam logic [1:0] OP_BLANK = 2'd2;
   localparam logic [1:0] OP_TICK  = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] REG_WAIT_TICKS = 2'd0;
   localparam logic [1:0] REG_LOW_TICKS  = 2'd1;
   localparam logic [1:0] REG_HIGH_TICKS = 2'd2;

   // Command and control bytes sent on the wire
   localparam logic [7:0] CMD_DATA    = 8'h40;
   localparam logic [7:0] CMD_ADDR    = 8'hC0;
   localparam logic [7:0] CTRL_BLANK  = 8'h80;
   localparam logic [7:0] TICK_MIN    = 8'h01;

   localparam int GRID_DEPTH = 16;

   typedef struct packed {
      logic [1:0] op;
      logic [3:0] grid_index;
      logic [7:0] grid_value;
      logic [7:0] light_byte;
   } req_type;

   typedef struct packed {
      logic clk_pin;
      logic dout_pin;
      logic busy_res;
   } rsp_type;

endpackage

>>> rtl/led_driver_two_wire_frame_writer_top.sv
// Two-wire LED driver frame writer: grid store, frame sequencer and pin levels.
//
// Takes one command word in every clock cycle (busy never asserts) and answers
// each with exactly one result word, strobed on rsp_valid in the cycle after start
// is sampled. The receiver cannot stall: each result word is shown for that one
// cycle only and must be taken then. The sequencer state and the result register
// form a single register stage, so the rate is one word per cycle. Tick words
// advance the waveform; each phase lasts its configured tick count (a count of
// zero acts as one). Load, send and blank words are dropped while a frame is
// running; the result then repeats the current line levels.
module led_driver_two_wire_frame_writer_top #(
   parameter int GRID_COUNT = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ldfw_pkg::req_type req_data,
   output logic              rsp_valid,
   output ldfw_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);

   // Frame phase codes
   localparam logic [4:0] PH_IDLE      = 5'd0;
   localparam logic [4:0] PH_START1    = 5'd1;
   localparam logic [4:0] PH_BIT_CLOW  = 5'd2;
   localparam logic [4:0] PH_BIT_DATA  = 5'd3;
   localparam logic [4:0] PH_BIT_CHIGH = 5'd4;
   localparam logic [4:0] PH_S1_CLOW   = 5'd5;
   localparam logic [4:0] PH_S1_DLOW   = 5'd6;
   localparam logic [4:0] PH_S1_CHIGH  = 5'd7;
   localparam logic [4:0] PH_S1_DHIGH  = 5'd8;
   localparam logic [4:0] PH_START2    = 5'd9;
   localparam logic [4:0] PH_M_CLOW    = 5'd10;
   localparam logic [4:0] PH_M_DLOW    = 5'd11;
   localparam logic [4:0] PH_M_CHIGH   = 5'd12;
   localparam logic [4:0] PH_M_DHIGH   = 5'd13;
   localparam logic [4:0] PH_START3    = 5'd14;
   localparam logic [4:0] PH_E_CLOW    = 5'd15;
   localparam logic [4:0] PH_E_DLOW    = 5'd16;
   localparam logic [4:0] PH_E_CHIGH   = 5'd17;
   localparam logic [4:0] PH_E_DHIGH   = 5'd18;

   // Hold selectors
   localparam logic [1:0] HOLD_WAIT = 2'd0;
   localparam logic [1:0] HOLD_LOW  = 2'd1;
   localparam logic [1:0] HOLD_HIGH = 2'd2;

   // Byte positions in the frame
   localparam logic [4:0] BYTE_DATA_CMD = 5'd0;
   localparam logic [4:0] BYTE_ADDR_CMD = 5'd1;
   localparam logic [4:0] BYTE_LAST     = 5'(GRID_COUNT + 1);
   localparam logic [4:0] BYTE_CTRL     = 5'(GRID_COUNT + 2);
   localparam logic [2:0] BIT_LAST      = 3'd7;

   logic [4:0] phase_ff, phase_in;
   logic [4:0] byte_cnt_ff, byte_cnt_in;
   logic [2:0] bit_cnt_ff, bit_cnt_in;
   logic [7:0] tick_cnt_ff, tick_cnt_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] ctrl_ff, ctrl_in;
   logic       blank_ff, blank_in;
   logic       clk_lvl_ff, clk_lvl_in;
   logic       dout_lvl_ff, dout_lvl_in;
   logic [7:0] wait_ticks_ff, low_ticks_ff, high_ticks_ff;
   logic [7:0] grid_ff [ldfw_pkg::GRID_DEPTH];
   logic       rsp_valid_ff, rsp_valid_in;
   ldfw_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic       accept;
   logic       running;
   logic       grid_wr_en;
   logic       do_enter;
   logic [4:0] enter_phase;
   logic       enter_on_data;
   logic       enter_level;
   logic [1:0] enter_hold;
   logic [7:0] hold_raw;
   logic       do_load;
   logic [4:0] load_idx;
   logic [3:0] grid_rd_idx;
   logic [7:0] load_val;

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign running = (phase_ff != PH_IDLE);

   // Work out the next sequencer state for the accepted word
   always_comb begin
      phase_in      = phase_ff;
      byte_cnt_in   = byte_cnt_ff;
      bit_cnt_in    = bit_cnt_ff;
      tick_cnt_in   = tick_cnt_ff;
      shift_in      = shift_ff;
      ctrl_in       = ctrl_ff;
      blank_in      = blank_ff;
      clk_lvl_in    = clk_lvl_ff;
      dout_lvl_in   = dout_lvl_ff;
      grid_wr_en    = 1'b0;
      do_enter      = 1'b0;
      enter_phase   = PH_IDLE;
      enter_on_data = 1'b0;
      enter_level   = 1'b0;
      enter_hold    = HOLD_WAIT;
      do_load       = 1'b0;
      load_idx      = BYTE_DATA_CMD;
      hold_raw      = wait_ticks_ff;
      grid_rd_idx   = '0;
      load_val      = ldfw_pkg::CMD_DATA;

      if (accept) begin
         if (req_data.op == ldfw_pkg::OP_TICK) begin
            if (running) begin
               if (tick_cnt_ff > ldfw_pkg::TICK_MIN) begin
                  tick_cnt_in = tick_cnt_ff - 8'd1;
               end else begin
                  do_enter = 1'b1;
                  case (phase_ff)
                     PH_START1, PH_START2, PH_START3: begin
                        enter_phase = PH_BIT_CLOW;
                     end
                     PH_BIT_CLOW: begin
                        enter_phase   = PH_BIT_DATA;
                        enter_on_data = 1'b1;
                        enter_level   = shift_ff[0];
                        enter_hold    = HOLD_LOW;
                     end
                     PH_BIT_DATA: begin
                        enter_phase = PH_BIT_CHIGH;
                        enter_level = 1'b1;
                        enter_hold  = HOLD_HIGH;
                     end
                     PH_BIT_CHIGH: begin
                        if (bit_cnt_ff < BIT_LAST) begin
                           bit_cnt_in  = bit_cnt_ff + 3'd1;
                           shift_in    = shift_ff >> 1;
                           enter_phase = PH_BIT_CLOW;
                        end else if (byte_cnt_ff == BYTE_DATA_CMD) begin
                           enter_phase = PH_S1_CLOW;
                        end else if (byte_cnt_ff >= BYTE_CTRL) begin
                           enter_phase = PH_E_CLOW;
                        end else if (byte_cnt_ff == BYTE_LAST) begin
                           enter_phase = PH_M_CLOW;
                        end else begin
                           do_load     = 1'b1;
                           load_idx    = byte_cnt_ff + 5'd1;
                           enter_phase = PH_BIT_CLOW;
                        end
                     end
                     PH_S1_CLOW, PH_M_CLOW, PH_E_CLOW: begin
                        enter_phase   = phase_ff + 5'd1;
                        enter_on_data = 1'b1;
                        enter_hold    = HOLD_LOW;
                     end
                     PH_S1_DLOW, PH_M_DLOW, PH_E_DLOW: begin
                        enter_phase = phase_ff + 5'd1;
                        enter_level = 1'b1;
                     end
                     PH_S1_CHIGH, PH_E_CHIGH: begin
                        enter_phase   = phase_ff + 5'd1;
                        enter_on_data = 1'b1;
                        enter_level   = 1'b1;
                     end
                     PH_M_CHIGH: begin
                        enter_phase   = PH_M_DHIGH;
                        enter_on_data = 1'b1;
                        enter_level   = 1'b1;
                        enter_hold    = HOLD_HIGH;
                     end
                     PH_S1_DHIGH: begin
                        do_load       = 1'b1;
                        load_idx      = BYTE_ADDR_CMD;
                        enter_phase   = PH_START2;
                        enter_on_data = 1'b1;
                     end
                     PH_M_DHIGH: begin
                        do_load       = 1'b1;
                        load_idx      = BYTE_CTRL;
                        enter_phase   = PH_START3;
                        enter_on_data = 1'b1;
                     end
                     default: begin
                        // Final stop done, or a stray code: drop back to idle
                        do_enter    = 1'b0;
                        phase_in    = PH_IDLE;
                        tick_cnt_in = 8'd0;
                     end
                  endcase
               end
            end
         end else if (!running) begin
            if (req_data.op == ldfw_pkg::OP_LOAD) begin
               grid_wr_en = 1'b1;
            end else begin
               blank_in      = (req_data.op == ldfw_pkg::OP_BLANK);
               ctrl_in       = blank_in ? ldfw_pkg::CTRL_BLANK : req_data.light_byte;
               do_load       = 1'b1;
               load_idx      = BYTE_DATA_CMD;
               do_enter      = 1'b1;
               enter_phase   = PH_START1;
               enter_on_data = 1'b1;
            end
         end
      end

      // Fetch the next byte to shift out
      grid_rd_idx = 4'(load_idx - 5'd2);
      if (load_idx == BYTE_DATA_CMD) begin
         load_val = ldfw_pkg::CMD_DATA;
      end else if (load_idx == BYTE_ADDR_CMD) begin
         load_val = ldfw_pkg::CMD_ADDR;
      end else if (load_idx >= BYTE_CTRL) begin
         load_val = ctrl_in;
      end else if (blank_in) begin
         load_val = 8'd0;
      end else begin
         load_val = grid_ff[grid_rd_idx];
      end
      if (do_load) begin
         byte_cnt_in = load_idx;
         bit_cnt_in  = 3'd0;
         shift_in    = load_val;
      end

      // Set one pin and load the phase hold count
      case (enter_hold)
         HOLD_LOW:  hold_raw = low_ticks_ff;
         HOLD_HIGH: hold_raw = high_ticks_ff;
         default:   hold_raw = wait_ticks_ff;
      endcase
      if (do_enter) begin
         phase_in = enter_phase;
         if (enter_on_data) begin
            dout_lvl_in = enter_level;
         end else begin
            clk_lvl_in = enter_level;
         end
         tick_cnt_in = (hold_raw == 8'd0) ? ldfw_pkg::TICK_MIN : hold_raw;
      end

      rsp_valid_in         = accept;
      rsp_data_in.clk_pin  = clk_lvl_in;
      rsp_data_in.dout_pin = dout_lvl_in;
      rsp_data_in.busy_res = (phase_in != PH_IDLE);
   end

   // Advance sequencer and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         byte_cnt_ff   <= '0;
         bit_cnt_ff    <= '0;
         tick_cnt_ff   <= '0;
         shift_ff      <= '0;
         ctrl_ff       <= '0;
         blank_ff      <= 1'b0;
         clk_lvl_ff    <= 1'b1;
         dout_lvl_ff   <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         byte_cnt_ff   <= byte_cnt_in;
         bit_cnt_ff    <= bit_cnt_in;
         tick_cnt_ff   <= tick_cnt_in;
         shift_ff      <= shift_in;
         ctrl_ff       <= ctrl_in;
         blank_ff      <= blank_in;
         clk_lvl_ff    <= clk_lvl_in;
         dout_lvl_ff   <= dout_lvl_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Hold the result word for its one strobed cycle
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wait_ticks_ff <= 8'd1;
         low_ticks_ff  <= 8'd1;
         high_ticks_ff <= 8'd1;
      end else if (csr_wr_en) begin
         case (csr_index)
            ldfw_pkg::REG_WAIT_TICKS: wait_ticks_ff <= csr_wdata;
            ldfw_pkg::REG_LOW_TICKS:  low_ticks_ff  <= csr_wdata;
            ldfw_pkg::REG_HIGH_TICKS: high_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Write the grid store; reset clears every entry
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ldfw_pkg::GRID_DEPTH; i++) begin
            grid_ff[i] <= 8'd0;
         end
      end else if (grid_wr_en) begin
         grid_ff[req_data.grid_index] <= req_data.grid_value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/ldfw_checker.sv
// Port-level checks for the frame writer, bound to the top level.
module ldfw_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input ldfw_pkg::req_type req_data,
   input logic              rsp_valid,
   input ldfw_pkg::rsp_type rsp_data
);

   // Every accepted word gets its result in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("accepted word produced no result word");

   // No result word without an accepted word
   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("result word without an accepted word");

   // Both lines rest high while no frame runs
   a_idle_lines: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.busy_res) |-> (rsp_data.clk_pin && rsp_data.dout_pin))
      else $error("line low while idle");

   // At most one line moves between back-to-back result words
   a_one_pin: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid)) |->
      !((rsp_data.clk_pin != $past(rsp_data.clk_pin)) &&
        (rsp_data.dout_pin != $past(rsp_data.dout_pin))))
      else $error("clock and data lines changed together");

   // A frame can only begin from a send or blank word
   a_frame_begin: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.op == ldfw_pkg::OP_LOAD)) |=>
      !(rsp_data.busy_res && !rsp_data.dout_pin && rsp_data.clk_pin &&
        $past(rsp_valid) && !$past(rsp_data.busy_res)))
      else $error("frame started by a load word");

endmodule

bind led_driver_two_wire_frame_writer_top ldfw_checker u_ldfw_checker (.*);

>>> tb/tb_led_driver_two_wire_frame_writer_top.sv
// Self-checking testbench for the two-wire LED driver frame writer top level.
module tb_led_driver_two_wire_frame_writer_top;

   localparam int GRID       = ldfw_pkg::GRID_DEPTH;
   localparam int RAND_WORDS = 500;
   localparam int STALL_MAX  = 2000;
   localparam int SETTLE_CYC = 4;
   localparam int CALM_FROM  = 800;
   localparam int CALM_TO    = 1300;

   typedef enum logic [4:0] {
      PH_IDLE, PH_START1, PH_BIT_CLOW, PH_BIT_DATA, PH_BIT_CHIGH,
      PH_S1_CLOW, PH_S1_DLOW, PH_S1_CHIGH, PH_S1_DHIGH, PH_START2,
      PH_M_CLOW, PH_M_DLOW, PH_M_CHIGH, PH_M_DHIGH, PH_START3,
      PH_E_CLOW, PH_E_DLOW, PH_E_CHIGH, PH_E_DHIGH
   } frame_phase_type;

   typedef enum logic [1:0] {HOLD_WAIT, HOLD_LOW, HOLD_HIGH} hold_sel_type;
   typedef enum logic {PIN_CLK, PIN_DOUT} pin_sel_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              start     = 1'b0;
   logic              busy;
   ldfw_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   ldfw_pkg::rsp_type rsp_data;
   logic              csr_wr_en = 1'b0;
   logic [1:0]        csr_index = ldfw_pkg::REG_WAIT_TICKS;
   logic [7:0]        csr_wdata = 8'd0;

   // Predicted block state
   logic [7:0]      cfg_wait = 8'd1;
   logic [7:0]      cfg_low  = 8'd1;
   logic [7:0]      cfg_high = 8'd1;
   logic [7:0]      grid_mem [GRID];
   frame_phase_type fr_phase = PH_IDLE;
   logic [4:0]      byte_idx = 5'd0;
   logic [2:0]      bit_idx  = 3'd0;
   logic [7:0]      hold_cnt = 8'd0;
   logic [7:0]      shifter  = 8'd0;
   logic [7:0]      ctrl_byte = 8'd0;
   logic            blank_on = 1'b0;
   logic            clk_lv   = 1'b1;
   logic            dat_lv   = 1'b1;

   ldfw_pkg::req_type cmd_words [$];
   ldfw_pkg::rsp_type pin_levels_due [$];
   int      words_taken = 0;
   int      err_cnt     = 0;
   int      stall_cyc   = 0;

   led_driver_two_wire_frame_writer_top #(
      .GRID_COUNT(GRID)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Byte sent at frame position b: commands, grid data, then control
   function automatic logic [7:0] frame_byte(input logic [4:0] b);
      logic [4:0] slot;
      slot = b - 5'd2;
      if (b == 5'd0) return ldfw_pkg::CMD_DATA;
      if (b == 5'd1) return ldfw_pkg::CMD_ADDR;
      if (b >= GRID + 2) return ctrl_byte;
      if (blank_on) return 8'h00;
      return grid_mem[slot[3:0]];
   endfunction

   function automatic void load_byte(input logic [4:0] b);
      byte_idx = b;
      bit_idx  = 3'd0;
      shifter  = frame_byte(b);
   endfunction

   // Move to a phase: set one pin, reload the hold count (zero acts as one)
   function automatic void enter_phase(input frame_phase_type ph, input pin_sel_type pin,
                                       input logic level, input hold_sel_type hold);
      logic [7:0] t;
      t = (hold == HOLD_WAIT) ? cfg_wait : (hold == HOLD_LOW) ? cfg_low : cfg_high;
      fr_phase = ph;
      if (pin == PIN_CLK) clk_lv = level;
      else dat_lv = level;
      hold_cnt = (t == 8'd0) ? ldfw_pkg::TICK_MIN : t;
   endfunction

   function automatic void advance_phase();
      case (fr_phase)
         PH_START1, PH_START2, PH_START3: enter_phase(PH_BIT_CLOW, PIN_CLK, 1'b0, HOLD_WAIT);
         PH_BIT_CLOW:  enter_phase(PH_BIT_DATA, PIN_DOUT, shifter[0], HOLD_LOW);
         PH_BIT_DATA:  enter_phase(PH_BIT_CHIGH, PIN_CLK, 1'b1, HOLD_HIGH);
         PH_BIT_CHIGH: begin
            if (bit_idx < 3'd7) begin
               bit_idx = bit_idx + 3'd1;
               shifter = shifter >> 1;
               enter_phase(PH_BIT_CLOW, PIN_CLK, 1'b0, HOLD_WAIT);
            end else if (byte_idx == 5'd0) begin
               enter_phase(PH_S1_CLOW, PIN_CLK, 1'b0, HOLD_WAIT);
            end else if (byte_idx >= GRID + 2) begin
               enter_phase(PH_E_CLOW, PIN_CLK, 1'b0, HOLD_WAIT);
            end else if (byte_idx == GRID + 1) begin
               enter_phase(PH_M_CLOW, PIN_CLK, 1'b0, HOLD_WAIT);
            end else begin
               load_byte(byte_idx + 5'd1);
               enter_phase(PH_BIT_CLOW, PIN_CLK, 1'b0, HOLD_WAIT);
            end
         end
         PH_S1_CLOW:  enter_phase(PH_S1_DLOW, PIN_DOUT, 1'b0, HOLD_LOW);
         PH_S1_DLOW:  enter_phase(PH_S1_CHIGH, PIN_CLK, 1'b1, HOLD_WAIT);
         PH_S1_CHIGH: enter_phase(PH_S1_DHIGH, PIN_DOUT, 1'b1, HOLD_WAIT);
         PH_S1_DHIGH: begin
            load_byte(5'd1);
            enter_phase(PH_START2, PIN_DOUT, 1'b0, HOLD_WAIT);
         end
         PH_M_CLOW:   enter_phase(PH_M_DLOW, PIN_DOUT, 1'b0, HOLD_LOW);
         PH_M_DLOW:   enter_phase(PH_M_CHIGH, PIN_CLK, 1'b1, HOLD_WAIT);
         PH_M_CHIGH:  enter_phase(PH_M_DHIGH, PIN_DOUT, 1'b1, HOLD_HIGH);
         PH_M_DHIGH: begin
            load_byte(5'(GRID + 2));
            enter_phase(PH_START3, PIN_DOUT, 1'b0, HOLD_WAIT);
         end
         PH_E_CLOW:   enter_phase(PH_E_DLOW, PIN_DOUT, 1'b0, HOLD_LOW);
         PH_E_DLOW:   enter_phase(PH_E_CHIGH, PIN_CLK, 1'b1, HOLD_WAIT);
         PH_E_CHIGH:  enter_phase(PH_E_DHIGH, PIN_DOUT, 1'b1, HOLD_WAIT);
         default: begin
            fr_phase = PH_IDLE;
            hold_cnt = 8'd0;
         end
      endcase
   endfunction

   // Apply one accepted word and return the pin levels that follow it
   function automatic ldfw_pkg::rsp_type next_pin_levels(input ldfw_pkg::req_type w);
      ldfw_pkg::rsp_type r;
      logic    running;
      running = (fr_phase != PH_IDLE);
      if (w.op == ldfw_pkg::OP_TICK) begin
         if (running) begin
            if (hold_cnt > 8'd1) hold_cnt = hold_cnt - 8'd1;
            else advance_phase();
         end
      end else if (!running) begin
         if (w.op == ldfw_pkg::OP_LOAD) begin
            grid_mem[w.grid_index] = w.grid_value;
         end else begin
            blank_on  = (w.op == ldfw_pkg::OP_BLANK);
            ctrl_byte = blank_on ? ldfw_pkg::CTRL_BLANK : w.light_byte;
            load_byte(5'd0);
            enter_phase(PH_START1, PIN_DOUT, 1'b0, HOLD_WAIT);
         end
      end
      r.clk_pin  = clk_lv;
      r.dout_pin = dat_lv;
      r.busy_res = (fr_phase != PH_IDLE);
      return r;
   endfunction

   function automatic ldfw_pkg::req_type cmd(input logic [1:0] op, input logic [3:0] idx,
                                             input logic [7:0] val, input logic [7:0] light);
      ldfw_pkg::req_type w;
      w.op         = op;
      w.grid_index = idx;
      w.grid_value = val;
      w.light_byte = light;
      return w;
   endfunction

   function automatic ldfw_pkg::req_type rand_cmd(input logic [1:0] op);
      return cmd(op, 4'($urandom_range(15)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
   endfunction

   // Drive words from the pending queue, idling at random outside the calm stretch
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            pin_levels_due.push_back(next_pin_levels(req_data));
            words_taken++;
         end
         if (!start || !busy) begin
            if (cmd_words.size() != 0 &&
                ((words_taken >= CALM_FROM && words_taken < CALM_TO) ||
                 $urandom_range(99) >= 36)) begin
               start    <= 1'b1;
               req_data <= cmd_words.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Compare each strobed result word with the oldest prediction
   always @(posedge clock) begin
      ldfw_pkg::rsp_type due;
      if (!reset && rsp_valid) begin
         if (pin_levels_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %b", $time, rsp_data);
            err_cnt++;
         end else begin
            due = pin_levels_due.pop_front();
            if (rsp_data.clk_pin !== due.clk_pin) begin
               $display("%0t: clk_pin expected %b actual %b", $time, due.clk_pin,
                        rsp_data.clk_pin);
               err_cnt++;
            end
            if (rsp_data.dout_pin !== due.dout_pin) begin
               $display("%0t: dout_pin expected %b actual %b", $time, due.dout_pin,
                        rsp_data.dout_pin);
               err_cnt++;
            end
            if (rsp_data.busy_res !== due.busy_res) begin
               $display("%0t: busy_res expected %b actual %b", $time, due.busy_res,
                        rsp_data.busy_res);
               err_cnt++;
            end
         end
      end
   end

   // Drop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cyc <= 0;
      end else if (stall_cyc >= STALL_MAX) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cyc <= stall_cyc + 1;
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         ldfw_pkg::REG_WAIT_TICKS: cfg_wait = val;
         ldfw_pkg::REG_LOW_TICKS:  cfg_low  = val;
         ldfw_pkg::REG_HIGH_TICKS: cfg_high = val;
         default: ;
      endcase
   endtask

   task automatic set_ticks(input logic [7:0] w, input logic [7:0] l, input logic [7:0] h);
      write_reg(ldfw_pkg::REG_WAIT_TICKS, w);
      write_reg(ldfw_pkg::REG_LOW_TICKS, l);
      write_reg(ldfw_pkg::REG_HIGH_TICKS, h);
   endtask

   // Wait until every queued word is taken and every result has come back
   task automatic wait_drained();
      @(posedge clock);
      while (cmd_words.size() != 0 || start || pin_levels_due.size() != 0)
         @(posedge clock);
   endtask

   // Tick out the running frame, then leave the block idle
   task automatic settle();
      forever begin
         wait_drained();
         if (fr_phase == PH_IDLE) break;
         repeat (64) cmd_words.push_back(rand_cmd(ldfw_pkg::OP_TICK));
      end
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   initial begin
      int made;
      int n;
      for (int i = 0; i < GRID; i++) grid_mem[i] = 8'h00;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle tick, store extremes, frame, words ignored while busy
      cmd_words.push_back(cmd(ldfw_pkg::OP_TICK, 4'd0, 8'h00, 8'h00));
      cmd_words.push_back(cmd(ldfw_pkg::OP_LOAD, 4'd0, 8'hFF, 8'h00));
      cmd_words.push_back(cmd(ldfw_pkg::OP_LOAD, 4'd15, 8'h80, 8'hFF));
      cmd_words.push_back(cmd(ldfw_pkg::OP_LOAD, 4'd7, 8'h01, 8'h00));
      cmd_words.push_back(cmd(ldfw_pkg::OP_LOAD, 4'd8, 8'h00, 8'hFF));
      cmd_words.push_back(cmd(ldfw_pkg::OP_SEND, 4'd0, 8'h00, 8'hFF));
      cmd_words.push_back(cmd(ldfw_pkg::OP_LOAD, 4'd3, 8'hAA, 8'h00));
      cmd_words.push_back(cmd(ldfw_pkg::OP_SEND, 4'd15, 8'hFF, 8'h00));
      cmd_words.push_back(cmd(ldfw_pkg::OP_BLANK, 4'd0, 8'h00, 8'h00));
      cmd_words.push_back(cmd(ldfw_pkg::OP_TICK, 4'd15, 8'hFF, 8'hFF));
      settle();

      // Random: two rounds of frames with random content, plus noise words;
      // the hold settings mix zero counts, which act as one, with two-tick holds
      for (int p = 0; p < 2; p++) begin
         case (p)
            0: set_ticks(8'd2, 8'd0, 8'd1);
            default: set_ticks(8'd0, 8'd2, 8'd0);
         endcase
         made = 0;
         while (made < RAND_WORDS / 2) begin
            wait_drained();
            if (fr_phase != PH_IDLE) begin
               n = $urandom_range(8, 40);
               for (int i = 0; i < n; i++) begin
                  if ($urandom_range(99) < 92) begin
                     cmd_words.push_back(rand_cmd(ldfw_pkg::OP_TICK));
                     made++;
                  end else begin
                     cmd_words.push_back(rand_cmd(2'($urandom_range(2))));
                  end
               end
            end else if ($urandom_range(99) < 75) begin
               n = $urandom_range(0, 4);
               for (int i = 0; i < n; i++) cmd_words.push_back(rand_cmd(ldfw_pkg::OP_LOAD));
               if ($urandom_range(99) < 70) cmd_words.push_back(rand_cmd(ldfw_pkg::OP_SEND));
               else cmd_words.push_back(rand_cmd(ldfw_pkg::OP_BLANK));
               made += n + 1;
            end else begin
               n = $urandom_range(1, 4);
               for (int i = 0; i < n; i++) begin
                  cmd_words.push_back(rand_cmd(2'($urandom_range(3))));
                  if (cmd_words[$].op != ldfw_pkg::OP_TICK) made++;
               end
            end
         end
         settle();
      end

      repeat (20) @(posedge clock);
      if (err_cnt == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
